// File: rtl/core/lbs_pkg.sv
// Shared widths, defaults and controller/datapath command and status types.
package lbs_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // store (or drop) the accepted element
        logic sort_step; // run one odd-even compare-and-swap round
        logic emit;      // head element taken, shift the store down
    } lbs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sort_done; // the current round is the final one
        logic emit_last; // the head element is the final one of the list
    } lbs_status_t;

endpackage

// File: rtl/core/lbs_channels.sv
// Valid/ready channel interfaces for elements, sorted results and configuration.
interface lbs_item_if
    import lbs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface lbs_result_if
    import lbs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

interface lbs_cfg_if;
    logic valid;
    logic ready;
    logic sort_descending;

    modport source (output valid, output sort_descending, input ready);
    modport sink   (input valid, input sort_descending, output ready);
endinterface

// File: rtl/core/lbs_datapath.sv
// Element store with a row of compare-and-swap cells, counters and mode register.
module lbs_datapath
    import lbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lbs_cmd_t                  cmd,
    input  logic signed [VALUE_W-1:0] load_value,
    input  logic                      cfg_write,
    input  logic                      cfg_descending,
    output lbs_status_t               status,
    output logic signed [VALUE_W-1:0] head_value,
    output logic                      head_last,
    output logic                      head_overflow
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] elem_reg  [DEPTH];
    logic signed [VALUE_W-1:0] elem_next [DEPTH];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          pass_reg;
    logic [CNT_W-1:0]          pass_next;
    logic                      dropped_reg;
    logic                      dropped_next;
    logic                      desc_reg;
    logic                      full;

    assign full = (count_reg == CNT_W'(DEPTH));

    // One odd-even round over the stored elements, or load, or shift down.
    always_comb
    begin
        logic swap;
        swap      = 1'b0;
        elem_next = elem_reg;
        if (cmd.load && !full)
        begin
            elem_next[count_reg[IDX_W-1:0]] = load_value;
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                swap = desc_reg ? (elem_reg[i] < elem_reg[i+1])
                                : (elem_reg[i] > elem_reg[i+1]);
                if ((1'(i) == pass_reg[0]) && (CNT_W'(i + 1) < count_reg) && swap)
                begin
                    elem_next[i]   = elem_reg[i+1];
                    elem_next[i+1] = elem_reg[i];
                end
            end
        end
        else if (cmd.emit)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                elem_next[j] = elem_reg[j+1];
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pass_next    = pass_reg;
        if (cmd.load)
        begin
            pass_next = '0;
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (cmd.sort_step)
        begin
            pass_next = pass_reg + CNT_W'(1);
        end
        else if (cmd.emit)
        begin
            count_next = count_reg - CNT_W'(1);
            if (status.emit_last)
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pass_reg    <= '0;
            dropped_reg <= 1'b0;
            desc_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            dropped_reg <= dropped_next;
            if (cfg_write)
            begin
                desc_reg <= cfg_descending;
            end
        end
    end

    assign status.sort_done = ((pass_reg + CNT_W'(1)) >= count_reg);
    assign status.emit_last = (count_reg == CNT_W'(1));

    assign head_value    = elem_reg[0];
    assign head_last     = status.emit_last;
    assign head_overflow = dropped_reg;

endmodule

// File: rtl/core/lbs_controller.sv
// Load / sort / emit sequencer driving the datapath and the channel handshakes.
module lbs_controller
    import lbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    input  logic        out_ready,
    input  lbs_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output lbs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_ready_reg && in_last)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (status.sort_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_valid_reg && out_ready && status.emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_LOAD);
            out_valid_reg <= (state_next == ST_EMIT);
        end
    end

    assign cmd.load      = in_valid && in_ready_reg;
    assign cmd.sort_step = (state_reg == ST_SORT);
    assign cmd.emit      = out_valid_reg && out_ready;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/list_bubble_sort_core.sv
// Top level of the list sorter: channel ports, controller and datapath.
//
// The block collects a list of signed 32-bit elements, one request per cycle,
// until a request with last_in set; up to DEPTH elements are kept and any
// further ones are dropped, in which case every result of that list carries
// overflow. The stored list is then sorted by odd-even transposition: a row
// of DEPTH-1 compare-and-swap cells runs one round per cycle, and N rounds
// (at least one) order N stored elements. The sort is stable, so equal
// values leave in arrival order, giving the same order as a bubble sort.
// Results then leave one per cycle from the head of the store while the sink
// holds ready high, the final one marked with last_out. No elements are taken
// while a list is sorting or emitting, and results wait for as long as the
// sink holds ready low. sort_descending (0 non-decreasing, 1 non-increasing)
// is written through the configuration channel, which is always ready, and
// should only change between lists.
module list_bubble_sort_core
    import lbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic         clk,
    input logic         rst_n,
    lbs_item_if.sink    elements,
    lbs_result_if.source sorted,
    lbs_cfg_if.sink     cfg
);

    lbs_cmd_t    cmd;
    lbs_status_t status;

    // Register writes are taken in any cycle
    assign cfg.ready = 1'b1;

    lbs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elements.valid),
        .in_last   (elements.last_in),
        .out_ready (sorted.ready),
        .status    (status),
        .in_ready  (elements.ready),
        .out_valid (sorted.valid),
        .cmd       (cmd)
    );

    // Hold the list, sort it in place and present the head as the result
    lbs_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .load_value     (elements.value),
        .cfg_write      (cfg.valid),
        .cfg_descending (cfg.sort_descending),
        .status         (status),
        .head_value     (sorted.sorted_value),
        .head_last      (sorted.last_out),
        .head_overflow  (sorted.overflow)
    );

endmodule

// File: rtl/core/lbs_checker.sv
// Port-level assertions for the list sorter, bound to the top level.
module lbs_checker
    import lbs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_last,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] out_value,
    input logic                      out_last,
    input logic                      out_overflow
);

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // Stop taking requests once the list has ended
    a_close_list: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("request taken after the final element");

    // Drop result valid after the final result
    a_end_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> !out_valid)
        else $error("result offered after the final one");

    // Keep emitting with the same overflow flag within one list
    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && (out_overflow == $past(out_overflow))))
        else $error("list emission broken or overflow changed");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
        else $error("stalled result changed");

endmodule

bind list_bubble_sort_core lbs_checker u_lbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (elements.valid),
    .in_ready     (elements.ready),
    .in_last      (elements.last_in),
    .out_valid    (sorted.valid),
    .out_ready    (sorted.ready),
    .out_value    (sorted.sorted_value),
    .out_last     (sorted.last_out),
    .out_overflow (sorted.overflow)
);

// File: dv/tb_list_bubble_sort_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for list_bubble_sort_core, with directed and random lists.
module tb_list_bubble_sort_core;
    import lbs_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    // Long receiver hold-off, so that the store fills and the input stalls
    localparam int HOLD_CYCLES = 400;
    // Quiet time after the last result: a full load, sort and emit of one list
    localparam int SETTLE      = 3 * DEPTH + 16;

    typedef enum int
    {
        PH_DIRECTED,
        PH_STEADY,
        PH_SLOW_SOURCE,
        PH_SLOW_SINK,
        PH_BOTH_SLOW,
        PH_BACKLOG
    } run_phase_t;

    typedef struct
    {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } element_req_t;

    typedef struct
    {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } sorted_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Locally owned drive values, each written by exactly one process
    logic                      item_valid   = 1'b0;
    logic signed [VALUE_W-1:0] item_value   = '0;
    logic                      item_last    = 1'b0;
    logic                      item_taken   = 1'b0;
    logic                      result_ready = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_desc     = 1'b0;

    run_phase_t run_phase      = PH_DIRECTED;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         hold_left      = 0;
    bit         backlog_done   = 1'b0;

    element_req_t   pending_reqs[$];
    sorted_result_t expected_results[$];

    // Shadow of the sorter: store, fill level, drop flag and sort order
    logic signed [VALUE_W-1:0] list_store [DEPTH];
    int                        list_count = 0;
    bit                        list_dropped = 1'b0;
    bit                        desc_mode = 1'b0;

    int reqs_queued     = 0;
    int reqs_accepted   = 0;
    int lists_closed    = 0;
    int overflow_lists  = 0;
    int results_checked = 0;
    int fail_count      = 0;

    lbs_item_if   element_bus();
    lbs_result_if result_bus();
    lbs_cfg_if    cfg_bus();

    assign element_bus.valid   = item_valid;
    assign element_bus.value   = item_value;
    assign element_bus.last_in = item_last;
    assign result_bus.ready    = result_ready;
    assign cfg_bus.valid       = cfg_valid;
    assign cfg_bus.sort_descending = cfg_desc;

    list_bubble_sort_core #(.DEPTH(DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (element_bus),
        .sorted   (result_bus),
        .cfg      (cfg_bus)
    );

    always #2 clk = ~clk;

    // Store one accepted request, or drop it when full; on the last one,
    // sort the list with a stable bubble sort and queue its results.
    task automatic take_request(input logic signed [VALUE_W-1:0] v, input logic last);
        logic signed [VALUE_W-1:0] held;
        sorted_result_t            r;
        if (list_count < DEPTH)
        begin
            list_store[list_count] = v;
            list_count++;
        end
        else
            list_dropped = 1'b1;
        reqs_accepted++;
        if (last)
        begin
            for (int pass = 0; pass + 1 < list_count; pass++)
            begin
                for (int i = 0; i + 1 < list_count; i++)
                begin
                    // Swap only on strict disorder, so equal values keep their order
                    if (desc_mode ? (list_store[i] < list_store[i+1])
                                  : (list_store[i] > list_store[i+1]))
                    begin
                        held            = list_store[i];
                        list_store[i]   = list_store[i+1];
                        list_store[i+1] = held;
                    end
                end
            end
            for (int k = 0; k < list_count; k++)
            begin
                r.sorted_value = list_store[k];
                r.last_out     = (k == list_count - 1);
                r.overflow     = list_dropped;
                expected_results.push_back(r);
            end
            lists_closed++;
            if (list_dropped)
                overflow_lists++;
            list_count   = 0;
            list_dropped = 1'b0;
        end
    endtask

    // Compare one delivered result with the oldest one outstanding
    task automatic check_result();
        sorted_result_t e;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result: sorted_value %0d", result_bus.sorted_value);
            fail_count++;
        end
        else
        begin
            e = expected_results.pop_front();
            results_checked++;
            if (result_bus.sorted_value !== e.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d",
                       e.sorted_value, result_bus.sorted_value);
                fail_count++;
            end
            if (result_bus.last_out !== e.last_out)
            begin
                $error("last_out: expected %0b, got %0b", e.last_out, result_bus.last_out);
                fail_count++;
            end
            if (result_bus.overflow !== e.overflow)
            begin
                $error("overflow: expected %0b, got %0b", e.overflow, result_bus.overflow);
                fail_count++;
            end
        end
    endtask

    // Monitor: sample both handshakes at the rising edge, predict before checking
    always @(posedge clk)
    begin
        item_taken <= item_valid && element_bus.ready;
        if (rst_n)
        begin
            if (item_valid && element_bus.ready)
                take_request(item_value, item_last);
            if (result_bus.valid && result_ready)
                check_result();
        end
    end

    // Driver: advance to the next pending request once the current one is
    // taken; hold it while the block refuses it; idle at the phase's rate.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                item_valid <= 1'b1;
                item_value <= pending_reqs[0].value;
                item_last  <= pending_reqs[0].last_in;
                void'(pending_reqs.pop_front());
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off at the start of the
    // backlog phase while the driver keeps offering requests.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (run_phase == PH_BACKLOG && !backlog_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            backlog_done <= 1'b1;
        end
        else
            result_ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom;
            // Narrow range: plenty of equal values within a list
            5, 6, 7:       return int'($urandom_range(8)) - 4;
            8:             return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:       return $urandom_range(1) ? 0 : -1;
        endcase
    endfunction

    // Mostly short lists, some long ones, some full and some overflowing
    function automatic int random_length();
        case ($urandom_range(19))
            14, 15, 16: return $urandom_range(DEPTH - 1, 7);
            17:         return DEPTH;
            18, 19:     return $urandom_range(DEPTH + 4, DEPTH + 1);
            default:    return $urandom_range(6, 1);
        endcase
    endfunction

    task automatic push_req(input logic signed [VALUE_W-1:0] v, input bit last);
        element_req_t q;
        q.value   = v;
        q.last_in = last;
        pending_reqs.push_back(q);
        reqs_queued++;
    endtask

    task automatic queue_random_lists(input int target);
        int added;
        int n;
        added = 0;
        while (added < target)
        begin
            n = random_length();
            for (int k = 0; k < n; k++)
                push_req(random_value(), k == n - 1);
            added += n;
        end
    endtask

    // Switch phase at a rising edge, clear of the falling-edge drivers
    task automatic enter_phase(input run_phase_t ph, input int src_pct, input int sink_pct);
        @(posedge clk);
        run_phase      = ph;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Hold until every queued request is taken and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (reqs_accepted != reqs_queued || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Write the sort order; the block is idle whenever this is called
    task automatic write_order(input bit descending);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_desc  <= descending;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        desc_mode = descending;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Ascending order from reset: extremes, duplicates, a one-element list
        enter_phase(PH_DIRECTED, 0, 0);
        push_req(32'sh7FFF_FFFF, 1'b0);
        push_req(1, 1'b0);
        push_req(0, 1'b0);
        push_req(32'sh8000_0000, 1'b0);
        push_req(-1, 1'b0);
        push_req(32'sh8000_0000, 1'b1);
        push_req(-5, 1'b1);
        wait_drained();

        // Descending order: a full store, then a dropped request that ends the list
        write_order(1'b1);
        enter_phase(PH_DIRECTED, 0, 0);
        push_req(32'sh7FFF_FFFF, 1'b0);
        push_req(32'sh8000_0000, 1'b0);
        push_req(0, 1'b0);
        push_req(-1, 1'b0);
        push_req(1, 1'b0);
        push_req(32'sh7FFF_FFFF, 1'b0);
        push_req(32'sh8000_0000, 1'b0);
        push_req(3, 1'b0);
        push_req(3, 1'b0);
        push_req(-3, 1'b0);
        push_req(32'sh5555_5555, 1'b0);
        push_req(32'shAAAA_AAAA, 1'b0);
        push_req(7, 1'b0);
        push_req(-7, 1'b0);
        push_req(2, 1'b0);
        push_req(-2, 1'b0);
        push_req(100, 1'b1);
        wait_drained();

        // Random lists; each phase ends on a whole list and drains fully
        write_order(1'b0);
        enter_phase(PH_STEADY, 0, 0);
        queue_random_lists(28);
        wait_drained();

        write_order(1'b1);
        enter_phase(PH_SLOW_SOURCE, 72, 0);
        queue_random_lists(28);
        wait_drained();

        write_order(1'b0);
        enter_phase(PH_SLOW_SINK, 0, 72);
        queue_random_lists(28);
        wait_drained();

        write_order(1'b1);
        enter_phase(PH_BOTH_SLOW, 12, 12);
        queue_random_lists(28);
        wait_drained();

        write_order(1'b0);
        enter_phase(PH_BACKLOG, 0, 0);
        queue_random_lists(28);
        wait_drained();

        // Let any stray result surface before the verdict
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d sorted results never arrived", expected_results.size());
            fail_count++;
        end

        $display("Covered %0d requests in %0d lists (%0d overflowing), %0d results checked,",
                 reqs_accepted, lists_closed, overflow_lists, results_checked);
        $display("in both sort orders with source/sink stalls and a %0d-cycle sink hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #400_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
